// ----- hw/rtl/owb_pkg.sv -----
// Package for the 1-Wire bus master: command codes, phases, slot timing constants.
package owb_pkg;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_RESET = 3'd1,
    OP_WBYTE = 3'd2,
    OP_RBYTE = 3'd3,
    OP_WBIT  = 3'd4,
    OP_RBIT  = 3'd5
  } op_e;

  typedef enum logic {
    PH_IDLE   = 1'b0,
    PH_ACTIVE = 1'b1
  } phase_e;

  localparam int unsigned CntW = 10;

  localparam logic [CntW-1:0] RstLow   = CntW'(480);
  localparam logic [CntW-1:0] RstWait  = CntW'(70);
  localparam logic [CntW-1:0] RstTail  = CntW'(410);
  localparam logic [CntW-1:0] W1Low    = CntW'(6);
  localparam logic [CntW-1:0] W1High   = CntW'(64);
  localparam logic [CntW-1:0] W0Low    = CntW'(60);
  localparam logic [CntW-1:0] W0High   = CntW'(10);
  localparam logic [CntW-1:0] RdLow    = CntW'(6);
  localparam logic [CntW-1:0] RdWait   = CntW'(9);
  localparam logic [CntW-1:0] RdTail   = CntW'(55);

  localparam logic [CntW-1:0] RstSample = RstLow + RstWait;
  localparam logic [CntW-1:0] RstLast   = RstLow + RstWait + RstTail - CntW'(1);
  localparam logic [CntW-1:0] W1Last    = W1Low + W1High - CntW'(1);
  localparam logic [CntW-1:0] W0Last    = W0Low + W0High - CntW'(1);
  localparam logic [CntW-1:0] RdSample  = RdLow + RdWait;
  localparam logic [CntW-1:0] RdLast    = RdLow + RdWait + RdTail - CntW'(1);

  typedef struct packed {
    logic drive;
    logic sample;
    logic slot_end;
  } slot_t;

endpackage

// ----- hw/rtl/owb_if.sv -----
// Channel interfaces for the 1-Wire bus master: tick/command beats and result beats.
interface owb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] data;
  logic       bus_sample;

  modport source (output valid, output op, output data, output bus_sample, input ready);
  modport sink   (input valid, input op, input data, input bus_sample, output ready);
endinterface

interface owb_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_value;
  logic       presence;
  logic       rejected;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output read_value, output presence, output rejected, input ready);
  modport sink   (input valid, input drive_low, input busy_res, input done_res,
                  input read_value, input presence, input rejected, output ready);
endinterface

// ----- hw/rtl/owb_slot.sv -----
// Slot timing decode: drive window, sample point and slot end for the current tick.
module owb_slot (
  input  owb_pkg::op_e               kind_i,
  input  logic [owb_pkg::CntW-1:0]   cnt_i,
  input  logic                       wr_bit_i,
  output owb_pkg::slot_t             slot_o
);

  always_comb begin
    slot_o = '0;
    case (kind_i)
      owb_pkg::OP_RESET: begin
        slot_o.drive    = cnt_i < owb_pkg::RstLow;
        slot_o.sample   = cnt_i == owb_pkg::RstSample;
        slot_o.slot_end = cnt_i >= owb_pkg::RstLast;
      end
      owb_pkg::OP_WBYTE, owb_pkg::OP_WBIT: begin
        if (wr_bit_i) begin
          slot_o.drive    = cnt_i < owb_pkg::W1Low;
          slot_o.slot_end = cnt_i >= owb_pkg::W1Last;
        end else begin
          slot_o.drive    = cnt_i < owb_pkg::W0Low;
          slot_o.slot_end = cnt_i >= owb_pkg::W0Last;
        end
      end
      default: begin
        slot_o.drive    = cnt_i < owb_pkg::RdLow;
        slot_o.sample   = cnt_i == owb_pkg::RdSample;
        slot_o.slot_end = cnt_i >= owb_pkg::RdLast;
      end
    endcase
  end

endmodule

// ----- hw/rtl/one_wire_bus_master.sv -----
// 1-Wire bus master, standard speed: one beat per microsecond tick.
// Result: the result for a tick is registered and is on the output in the cycle after the beat is taken.
// Throughput: one tick per cycle while the output is taken; a new beat is taken while the output register empties.
// Slot state and the result register form the only timing loop.
// Reset: asynchronous, active low; idle, counters, shift and read hold cleared.
module one_wire_bus_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  owb_in_if.sink      in_i,
  owb_out_if.source   out_o
);

  owb_pkg::phase_e            phase_q, phase_d;
  owb_pkg::op_e               kind_q, kind_d;
  logic [owb_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [2:0]                 bidx_q, bidx_d;
  logic [7:0]                 sh_q, sh_d;
  logic [7:0]                 hold_q, hold_d;
  logic                       pres_q, pres_d;

  logic                       out_valid_q;
  logic                       drive_q, busy_q, done_q, rej_q;

  logic                       accept, is_cmd, start, active, last, done;
  owb_pkg::op_e               op_in, kind;
  logic [owb_pkg::CntW-1:0]   cnt;
  logic [2:0]                 bidx;
  logic [7:0]                 sh;
  owb_pkg::slot_t             slot;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign op_in  = owb_pkg::op_e'(in_i.op);
  assign is_cmd = in_i.op inside {[owb_pkg::OP_RESET:owb_pkg::OP_RBIT]};
  assign start  = (phase_q == owb_pkg::PH_IDLE) && is_cmd;
  assign active = start || (phase_q == owb_pkg::PH_ACTIVE);

  assign kind = start ? op_in : kind_q;
  assign cnt  = start ? '0 : cnt_q;
  assign bidx = start ? 3'd0 : bidx_q;

  always_comb begin
    if (start) begin
      sh = ((op_in == owb_pkg::OP_WBYTE) || (op_in == owb_pkg::OP_WBIT)) ? in_i.data : 8'd0;
    end else begin
      sh = sh_q;
    end
  end

  owb_slot u_slot (
    .kind_i   (kind),
    .cnt_i    (cnt),
    .wr_bit_i (sh[bidx]),
    .slot_o   (slot)
  );

  always_comb begin
    if ((kind == owb_pkg::OP_WBYTE) || (kind == owb_pkg::OP_RBYTE)) begin
      last = bidx == 3'd7;
    end else begin
      last = 1'b1;
    end
  end

  assign done = active && slot.slot_end && last;

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      owb_pkg::PH_IDLE:   if (start && !done) phase_d = owb_pkg::PH_ACTIVE;
      owb_pkg::PH_ACTIVE: if (done) phase_d = owb_pkg::PH_IDLE;
      default:            phase_d = owb_pkg::PH_IDLE;
    endcase
  end

  // slot datapath
  always_comb begin
    kind_d = kind_q;
    cnt_d  = cnt_q;
    bidx_d = bidx_q;
    sh_d   = sh_q;
    hold_d = hold_q;
    pres_d = pres_q;
    if (active) begin
      kind_d = kind;
      sh_d   = sh;
      if (slot.sample) begin
        if (kind == owb_pkg::OP_RESET) begin
          sh_d = {7'd0, ~in_i.bus_sample};
        end else begin
          sh_d = sh | (8'(in_i.bus_sample) << bidx);
        end
      end
      if (slot.slot_end) begin
        cnt_d = '0;
        if (last) begin
          bidx_d = 3'd0;
          if (kind == owb_pkg::OP_RESET) begin
            pres_d = sh_d[0];
          end else if ((kind == owb_pkg::OP_RBYTE) || (kind == owb_pkg::OP_RBIT)) begin
            hold_d = sh_d;
          end
        end else begin
          bidx_d = bidx + 3'd1;
        end
      end else begin
        cnt_d  = cnt + owb_pkg::CntW'(1);
        bidx_d = bidx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= owb_pkg::PH_IDLE;
      kind_q  <= owb_pkg::OP_TICK;
      cnt_q   <= '0;
      bidx_q  <= '0;
      sh_q    <= '0;
      hold_q  <= '0;
      pres_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      cnt_q   <= cnt_d;
      bidx_q  <= bidx_d;
      sh_q    <= sh_d;
      hold_q  <= hold_d;
      pres_q  <= pres_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      drive_q <= active && slot.drive;
      busy_q  <= active;
      done_q  <= done;
      rej_q   <= (phase_q != owb_pkg::PH_IDLE) && is_cmd;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.drive_low  = drive_q;
  assign out_o.busy_res   = busy_q;
  assign out_o.done_res   = done_q;
  assign out_o.read_value = hold_q;
  assign out_o.presence   = pres_q;
  assign out_o.rejected   = rej_q;

endmodule

// ----- tb/owb_scoreboard_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the 1-Wire bus master: a tick-level slot model of the master and result checking.
package owb_scoreboard_pkg;
  import owb_pkg::*;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       presence;
    logic       rejected;
  } owb_result_t;

  class owb_scoreboard;
    phase_e          phase;
    op_e             kind;
    logic [CntW-1:0] usec;
    logic [2:0]      bit_idx;
    logic [7:0]      shift_q;
    logic [7:0]      read_hold;
    logic            presence_q;
    owb_result_t     pending_results[$];
    int unsigned     mismatches;

    function new();
      phase      = PH_IDLE;
      kind       = OP_TICK;
      usec       = '0;
      bit_idx    = '0;
      shift_q    = '0;
      read_hold  = '0;
      presence_q = 1'b0;
      mismatches = 0;
    endfunction

    function logic write_bit();
      return (kind == OP_WBYTE) ? shift_q[bit_idx] : shift_q[0];
    endfunction

    function int unsigned slot_ticks();
      case (kind)
        OP_RESET: return int'(RstLow) + int'(RstWait) + int'(RstTail);
        OP_WBYTE, OP_WBIT: begin
          if (write_bit()) return int'(W1Low) + int'(W1High);
          return int'(W0Low) + int'(W0High);
        end
        default: return int'(RdLow) + int'(RdWait) + int'(RdTail);
      endcase
    endfunction

    // write slots never sample
    function int unsigned sample_tick();
      case (kind)
        OP_RESET: return int'(RstLow) + int'(RstWait);
        OP_RBYTE, OP_RBIT: return int'(RdLow) + int'(RdWait);
        default: return 1024;
      endcase
    endfunction

    // next tick closes the command, barring a fresh start
    function bit finishing();
      return phase == PH_ACTIVE && int'(usec) + 1 >= slot_ticks()
             && ((kind != OP_WBYTE && kind != OP_RBYTE) || bit_idx == 3'd7);
    endfunction

    function void note_tick(logic [2:0] op, logic [7:0] data, logic level);
      owb_result_t want;
      logic        is_cmd;
      want   = '0;
      is_cmd = (op >= OP_RESET) && (op <= OP_RBIT);
      if (phase != PH_IDLE) begin
        want.rejected = is_cmd;
      end else if (is_cmd) begin
        phase   = PH_ACTIVE;
        kind    = op_e'(op);
        usec    = '0;
        bit_idx = '0;
        shift_q = (kind == OP_WBYTE || kind == OP_WBIT) ? data : 8'h00;
      end
      if (phase == PH_ACTIVE) begin
        want.busy_res = 1'b1;
        case (kind)
          OP_RESET:          want.drive_low = usec < RstLow;
          OP_WBYTE, OP_WBIT: want.drive_low = usec < (write_bit() ? W1Low : W0Low);
          default:           want.drive_low = usec < RdLow;
        endcase
        if (int'(usec) == sample_tick()) begin
          if (kind == OP_RESET) shift_q = {7'd0, ~level};
          else shift_q = shift_q | (8'(level) << bit_idx);
        end
        if (finishing()) begin
          want.done_res = 1'b1;
          phase         = PH_IDLE;
          if (kind == OP_RESET) presence_q = shift_q[0];
          else if (kind == OP_RBYTE || kind == OP_RBIT) read_hold = shift_q;
          usec    = '0;
          bit_idx = '0;
        end else if (int'(usec) + 1 >= slot_ticks()) begin
          bit_idx = bit_idx + 3'd1;
          usec    = '0;
        end else begin
          usec = usec + 1'b1;
        end
      end
      want.read_value = read_hold;
      want.presence   = presence_q;
      pending_results.push_back(want);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_result(owb_result_t got);
      owb_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing pending, expected none, got %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("drive_low", 8'(want.drive_low), 8'(got.drive_low));
      compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
      compare_field("read_value", want.read_value, got.read_value);
      compare_field("presence", 8'(want.presence), 8'(got.presence));
      compare_field("rejected", 8'(want.rejected), 8'(got.rejected));
    endfunction
  endclass

endpackage

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for the 1-Wire bus master: directed and random slot traffic checked tick by tick.
module testbench;
  import owb_pkg::*;
  import owb_scoreboard_pkg::*;

  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

  // a reset slot alone is 960 ticks; the random bit slots fill the run up to this budget
  localparam int unsigned TickBudget = 1700;

  logic clk_i;
  logic rst_ni;

  owb_in_if  in_if ();
  owb_out_if out_if ();

  owb_scoreboard bus_model;
  int unsigned   ticks_sent;
  int unsigned   in_pace;
  int unsigned   pick;

  one_wire_bus_master DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("Regression FAIL");
    $finish;
  end

  // 0: no idling, 1: occasional gaps, 2: a random gap drawn on every beat
  function automatic int unsigned draw_gap(int unsigned pace);
    case (pace)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
      default: return $urandom_range(0, 19);
    endcase
  endfunction

  // line level for the tick about to go out: pattern bit at a sample point, noise elsewhere
  function automatic logic line_level(logic [7:0] pattern);
    if (bus_model.phase == PH_ACTIVE && int'(bus_model.usec) == bus_model.sample_tick())
      return pattern[bus_model.bit_idx];
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic send_tick(logic [2:0] op, logic [7:0] data, logic level);
    int unsigned gap;
    if (ticks_sent % 50 == 0) in_pace = $urandom_range(0, 2);
    gap = draw_gap(in_pace);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.op         <= op;
    in_if.data       <= data;
    in_if.bus_sample <= level;
    do @(posedge clk_i); while (!in_if.ready);
    bus_model.note_tick(op, data, level);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic run_command(op_e op, logic [7:0] data, logic [7:0] pattern,
                             int unsigned noise_pct, bit hit_done);
    logic [2:0]  busy_op;
    int unsigned idle_n;
    send_tick(op, data, line_level(pattern));
    while (bus_model.phase == PH_ACTIVE) begin
      if (hit_done && bus_model.finishing())
        busy_op = 3'($urandom_range(int'(OP_RESET), int'(OP_RBIT)));
      else if ($urandom_range(0, 99) < noise_pct)
        busy_op = 3'($urandom_range(int'(OP_RESET), int'(OpSpare7)));
      else
        busy_op = OP_TICK;
      send_tick(busy_op, 8'($urandom), line_level(pattern));
    end
    idle_n = $urandom_range(0, 4);
    repeat (idle_n) begin
      case ($urandom_range(0, 2))
        0: busy_op = OP_TICK;
        1: busy_op = OpSpare6;
        default: busy_op = OpSpare7;
      endcase
      send_tick(busy_op, 8'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin : ready_pacer
    int unsigned gap;
    int unsigned beats;
    int unsigned out_pace;
    out_if.ready = 1'b0;
    beats        = 0;
    out_pace     = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (beats % 50 == 0) out_pace = $urandom_range(0, 2);
      gap = draw_gap(out_pace);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      beats++;
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      bus_model.check_result(owb_result_t'{
        drive_low:  out_if.drive_low,
        busy_res:   out_if.busy_res,
        done_res:   out_if.done_res,
        read_value: out_if.read_value,
        presence:   out_if.presence,
        rejected:   out_if.rejected
      });
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.op         = OP_TICK;
    in_if.data       = 8'h00;
    in_if.bus_sample = 1'b1;
    rst_ni           = 1'b0;
    bus_model        = new();
    ticks_sent       = 0;
    in_pace          = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed
    send_tick(OP_TICK, 8'h00, 1'b0);
    send_tick(OpSpare6, 8'hFF, 1'b1);
    send_tick(OpSpare7, 8'h5A, 1'b0);
    run_command(OP_RESET, 8'h00, 8'h00, 2, 1'b1);   // device answers, command on done tick
    run_command(OP_RBYTE, 8'h3C, 8'hA5, 5, 1'b0);

    // random: short bit slots
    while (ticks_sent < TickBudget) begin
      pick = $urandom_range(0, 1);
      case (pick)
        0:       run_command(OP_WBIT, 8'($urandom), 8'($urandom),
                             $urandom_range(0, 10), $urandom_range(0, 3) == 0);
        default: run_command(OP_RBIT, 8'($urandom), 8'($urandom),
                             $urandom_range(0, 10), $urandom_range(0, 3) == 0);
      endcase
    end
    in_if.valid <= 1'b0;

    while (bus_model.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (bus_model.mismatches == 0 && bus_model.pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
